FILE: rtl/core/lrc_frame_receiver_assert.svh
// assertion macros used by the frame receiver checker
`ifndef LRC_FRAME_RECEIVER_ASSERT_SVH
`define LRC_FRAME_RECEIVER_ASSERT_SVH

// property checked on every clock edge outside reset
`define LRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked on every clock edge, reset included
`define LRC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/core/lrc_pkg.sv
// types, constants and packing for the lrc frame receiver
`timescale 1ns / 1ps

package lrc_pkg;

    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] END_BYTE   = 8'h7F;
    localparam logic [7:0] LRC_SKIP   = 8'hFF;

    localparam int N_CAPTURE = 5;
    localparam int IN_W      = 8;

    typedef struct packed {
        logic [7:0] data_byte3;
        logic [7:0] data_byte2;
        logic [7:0] data_byte1;
        logic [7:0] data_byte0;
        logic [7:0] opcode;
        logic       frame_ok;
    } result_t;

    localparam int RES_W    = $bits(result_t);
    // frame_ok travels in tuser, the other fields fill tdata
    localparam int FIELDS_W = RES_W - 1;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

    function automatic logic [TDATA_W-1:0] pack_result(input result_t res);
        logic [TDATA_W-1:0] word;
        word = '0;
        word[FIELDS_W-1:0] = res[RES_W-1:1];
        return word;
    endfunction

endpackage

FILE: rtl/core/lrc_parser.sv
// frame parser: start hunt, length, body capture with running lrc, end byte check
`timescale 1ns / 1ps

module lrc_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    output logic              res_valid,
    output lrc_pkg::result_t  res
);
    import lrc_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY,
        PH_END
    } phase_t;

    // body index saturates once past the captured bytes
    localparam logic [2:0] IDX_SAT = 3'(N_CAPTURE + 1);

    phase_t     phase_reg, phase_next;
    logic [7:0] left_reg, left_next;
    logic [2:0] idx_reg, idx_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] last_reg, last_next;
    logic [7:0] cap_reg [N_CAPTURE];
    logic [7:0] cap_next [N_CAPTURE];
    logic       lrc_ok;

    assign lrc_ok = (last_reg == LRC_SKIP) || (last_reg == xor_reg);

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        xor_next   = xor_reg;
        last_next  = last_reg;
        for (int i = 0; i < N_CAPTURE; i++) begin
            cap_next[i] = cap_reg[i];
        end
        res_valid = 1'b0;
        res       = '0;

        if (in_valid) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (in_byte == START_BYTE) begin
                        for (int i = 0; i < N_CAPTURE; i++) begin
                            cap_next[i] = '0;
                        end
                        idx_next   = '0;
                        left_next  = '0;
                        xor_next   = '0;
                        last_next  = '0;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (in_byte == 8'd0) begin
                        phase_next = PH_HUNT;
                    end else begin
                        // length byte is body byte 0
                        idx_next   = 3'd1;
                        xor_next   = '0;
                        last_next  = in_byte;
                        left_next  = in_byte - 8'd1;
                        phase_next = (in_byte == 8'd1) ? PH_END : PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (idx_reg >= 3'd1 && idx_reg <= 3'(N_CAPTURE)) begin
                        cap_next[idx_reg - 3'd1] = in_byte;
                    end
                    xor_next  = xor_reg ^ last_reg;
                    last_next = in_byte;
                    if (idx_reg != IDX_SAT) begin
                        idx_next = idx_reg + 3'd1;
                    end
                    if (left_reg <= 8'd1) begin
                        left_next  = '0;
                        phase_next = PH_END;
                    end else begin
                        left_next = left_reg - 8'd1;
                    end
                end
                PH_END: begin
                    phase_next = PH_HUNT;
                    if (in_byte == END_BYTE) begin
                        res_valid = 1'b1;
                        if (lrc_ok) begin
                            res.frame_ok   = 1'b1;
                            res.opcode     = cap_reg[0];
                            res.data_byte0 = cap_reg[1];
                            res.data_byte1 = cap_reg[2];
                            res.data_byte2 = cap_reg[3];
                            res.data_byte3 = cap_reg[4];
                        end
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            left_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
        end
        xor_reg  <= xor_next;
        last_reg <= last_next;
        for (int i = 0; i < N_CAPTURE; i++) begin
            cap_reg[i] <= cap_next[i];
        end
    end

endmodule

FILE: rtl/core/lrc_out_stage.sv
// result register with skid slot between parser and master side
`timescale 1ns / 1ps

module lrc_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  lrc_pkg::result_t  res,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output lrc_pkg::result_t  out_res
);
    import lrc_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_fire;

    assign out_fire  = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // no new result can arrive while the skid slot is full
            if (out_fire) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || out_fire) begin
                out_data_reg  <= res;
                out_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= res;
                skid_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: rtl/core/lrc_frame_receiver.sv
// top level of the byte-serial lrc frame receiver
// a result is registered in the output stage after the closing 0x7f transfer
// throughput: one byte per cycle while s_tready is high, no frame gap needed
// s_tready falls only while a second result waits in the skid slot behind a stalled output
// reset: synchronous active-low aresetn returns to start hunt and empties the output stage
`timescale 1ns / 1ps

module lrc_frame_receiver (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lrc_pkg::IN_W-1:0]    s_tdata,   // [7:0] rx_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lrc_pkg::TDATA_W-1:0] m_tdata,   // [7:0] opcode, [15:8] data_byte0,
                                                   // [23:16] data_byte1, [31:24] data_byte2,
                                                   // [39:32] data_byte3
    output logic                        m_tuser    // [0] frame_ok
);
    import lrc_pkg::*;

    logic    s_fire;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign s_fire = s_tvalid && s_tready;

    lrc_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_fire),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    lrc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = pack_result(out_res);
    assign m_tuser = out_res.frame_ok;

endmodule

FILE: rtl/core/lrc_frame_receiver_check.sv
// port-level checker for the lrc frame receiver and its bind
`timescale 1ns / 1ps
`include "lrc_frame_receiver_assert.svh"

module lrc_frame_receiver_check (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [lrc_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tuser
);
    import lrc_pkg::*;

    `LRC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")
    `LRC_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped on stall")
    `LRC_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "data changed on stall")
    `LRC_ASSERT(a_hold_user, m_tvalid && !m_tready |=> $stable(m_tuser), "kind changed on stall")
    `LRC_ASSERT(a_err_zero, m_tvalid && !m_tuser |-> m_tdata == '0, "error result with fields")

endmodule

bind lrc_frame_receiver lrc_frame_receiver_check u_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
